// ===== hdl/gwp_pkg.sv =====
`default_nettype none
package gwp_pkg;

	localparam int FRAC_DIGITS = 4;
	localparam int P10_W = 24;
	localparam int PROD_W = 32 + P10_W;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	localparam logic [4:0] NO_WORD = 5'd31;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_SEMI = 8'd59;
	localparam logic [7:0] CH_POINT = 8'd46;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_LETTER_LO = 8'd65;
	localparam logic [7:0] CH_LETTER_HI = 8'd122;

	localparam logic [32:0] POS_LIM = 33'h0_7FFF_FFFF;
	localparam logic [32:0] NEG_LIM = 33'h0_8000_0000;

	typedef struct packed {
		logic [4:0] letter;
		logic [31:0] mag;
		logic neg;
		logic point;
		logic [2:0] frac_cnt;
		logic stopped;
		logic clamp;
		logic started;
	} word_t;

	localparam word_t WORD_CLEAR = '{letter: NO_WORD, default: '0};

	typedef struct packed {
		logic [4:0] letter;
		logic [31:0] mag;
		logic neg;
		logic [2:0] frac_cnt;
		logic clamp;
		logic last;
	} emit_t;

	typedef struct packed {
		logic [4:0] letter;
		logic signed [31:0] value;
		logic sat;
		logic last;
	} result_t;

	function automatic logic [4:0] letter_code(input logic [7:0] c);
		logic [4:0] code;
		case (c)
			8'h41: code = 5'd0;
			8'h42: code = 5'd1;
			8'h43: code = 5'd2;
			8'h58: code = 5'd3;
			8'h59: code = 5'd4;
			8'h5A: code = 5'd5;
			8'h49: code = 5'd6;
			8'h4A: code = 5'd7;
			8'h4B: code = 5'd8;
			8'h46: code = 5'd9;
			8'h53: code = 5'd10;
			8'h50: code = 5'd11;
			8'h52: code = 5'd12;
			8'h54: code = 5'd13;
			8'h4E: code = 5'd14;
			8'h4D: code = 5'd15;
			8'h47: code = 5'd16;
			default: code = NO_WORD;
		endcase
		return code;
	endfunction

	function automatic logic [P10_W-1:0] pow10(input logic [2:0] n);
		logic [P10_W-1:0] p;
		case (n)
			3'd0: p = P10_W'(1);
			3'd1: p = P10_W'(10);
			3'd2: p = P10_W'(100);
			3'd3: p = P10_W'(1000);
			3'd4: p = P10_W'(10000);
			3'd5: p = P10_W'(100000);
			3'd6: p = P10_W'(1000000);
			3'd7: p = P10_W'(10000000);
			default: p = P10_W'(1);
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/gwp_scale.sv =====
`default_nettype none
module gwp_scale (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic a_vld_s1,
	input wire gwp_pkg::emit_t a_s1,
	input wire logic b_vld_s1,
	input wire logic [4:0] b_letter_s1,
	output logic push_a,
	output gwp_pkg::result_t res_a,
	output logic push_b,
	output gwp_pkg::result_t res_b
);

	logic a_vld_s2;
	logic b_vld_s2;
	logic [gwp_pkg::PROD_W-1:0] prod_s2;
	logic [4:0] a_letter_s2;
	logic a_neg_s2;
	logic a_clamp_s2;
	logic a_last_s2;
	logic [4:0] b_letter_s2;

	logic [gwp_pkg::PROD_W-1:0] bound;
	logic [gwp_pkg::PROD_W-1:0] mag_sat;
	logic over;
	logic [31:0] mag32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s2 <= 1'b0;
			b_vld_s2 <= 1'b0;
		end else begin
			a_vld_s2 <= a_vld_s1;
			b_vld_s2 <= b_vld_s1;
		end
	end

	// scale to fixed point: magnitude times 10^(digits still missing)
	always_ff @(posedge clk) begin
		prod_s2 <= gwp_pkg::PROD_W'(a_s1.mag)
			* gwp_pkg::PROD_W'(gwp_pkg::pow10(3'(gwp_pkg::FRAC_DIGITS) - a_s1.frac_cnt));
		a_letter_s2 <= a_s1.letter;
		a_neg_s2 <= a_s1.neg;
		a_clamp_s2 <= a_s1.clamp;
		a_last_s2 <= a_s1.last;
		b_letter_s2 <= b_letter_s1;
	end

	always_comb begin
		bound = a_neg_s2 ? gwp_pkg::PROD_W'(gwp_pkg::NEG_LIM)
			: gwp_pkg::PROD_W'(gwp_pkg::POS_LIM);
		over = prod_s2 > bound;
		mag_sat = over ? bound : prod_s2;
		mag32 = mag_sat[31:0];
		push_a = a_vld_s2;
		res_a.letter = a_letter_s2;
		res_a.value = a_neg_s2 ? -$signed(mag32) : $signed(mag32);
		res_a.sat = a_clamp_s2 | over;
		res_a.last = a_last_s2;
		push_b = b_vld_s2;
		res_b.letter = b_letter_s2;
		res_b.value = '0;
		res_b.sat = 1'b0;
		res_b.last = 1'b1;
	end

endmodule
`default_nettype wire

// ===== hdl/gcode_word_parser_top.sv =====
`default_nettype none
// G-code word splitter: takes one character per cycle while in_ready is high and
// returns each known word (letter code A B C X Y Z I J K F S P R T N M G as 0..16)
// with its value times 10^4, truncated and saturated to 32 bits. A space, a
// semicolon, a letter or line_end closes a word; a semicolon drops the rest of the
// line. Each character yields at most two results, which pass the s1 and s2 stage
// registers into an 8-entry result queue and leave it one per cycle while out_ready
// is high.
// in_ready falls only when fewer than two queue entries are left unreserved, so the
// input runs at full rate as long as results are taken at the rate they are made.
module gcode_word_parser_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] char_code,
	input wire logic line_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic [4:0] word_letter,
	output logic signed [31:0] word_value,
	output logic value_saturated,
	output logic last_of_line
);

	gwp_pkg::word_t word_q;
	gwp_pkg::word_t word_n;
	gwp_pkg::word_t fed;
	logic comment_q;
	logic comment_n;

	logic is_digit;
	logic is_letter;
	logic [4:0] code;
	logic [3:0] digit;
	logic [35:0] acc_next;
	logic [35:0] acc_lim;
	logic acc_over;

	gwp_pkg::emit_t em_a;
	logic em_a_vld;
	logic em_b_vld;
	logic [4:0] em_b_letter;

	logic a_vld_s1;
	gwp_pkg::emit_t a_s1;
	logic b_vld_s1;
	logic [4:0] b_letter_s1;

	logic push_a;
	logic push_b;
	gwp_pkg::result_t res_a;
	gwp_pkg::result_t res_b;

	gwp_pkg::result_t mem_q [gwp_pkg::FIFO_DEPTH];
	logic [gwp_pkg::PTR_W-1:0] wr_ptr_q;
	logic [gwp_pkg::PTR_W-1:0] rd_ptr_q;
	logic [gwp_pkg::CNT_W-1:0] fill_q;
	logic [gwp_pkg::CNT_W-1:0] res_q;
	logic in_fire;
	logic out_fire;
	logic [gwp_pkg::CNT_W-1:0] n_new;
	logic [gwp_pkg::CNT_W-1:0] n_push;
	logic [gwp_pkg::CNT_W-1:0] n_pop;

	assign in_fire = in_valid & in_ready;
	assign out_fire = out_valid & out_ready;
	assign in_ready = res_q <= gwp_pkg::CNT_W'(gwp_pkg::FIFO_DEPTH - 2);

	// number accumulation
	always_comb begin
		is_digit = (char_code >= gwp_pkg::CH_ZERO) && (char_code <= gwp_pkg::CH_NINE);
		is_letter = char_code inside {[gwp_pkg::CH_LETTER_LO:gwp_pkg::CH_LETTER_HI]};
		code = gwp_pkg::letter_code(char_code);
		digit = 4'(char_code - gwp_pkg::CH_ZERO);
		acc_next = ({4'b0, word_q.mag} << 3) + ({4'b0, word_q.mag} << 1) + 36'(digit);
		acc_lim = word_q.neg ? 36'(gwp_pkg::NEG_LIM) : 36'(gwp_pkg::POS_LIM);
		acc_over = acc_next > acc_lim;

		fed = word_q;
		if (is_digit) begin
			fed.started = 1'b1;
			if (!word_q.point || (word_q.frac_cnt < 3'(gwp_pkg::FRAC_DIGITS))) begin
				fed.mag = acc_over ? acc_lim[31:0] : acc_next[31:0];
				fed.clamp = word_q.clamp | acc_over;
				if (word_q.point) begin
					fed.frac_cnt = word_q.frac_cnt + 3'd1;
				end
			end
		end else if (char_code == gwp_pkg::CH_POINT) begin
			if (word_q.point) begin
				fed.stopped = 1'b1;
			end else begin
				fed.point = 1'b1;
				fed.started = 1'b1;
			end
		end else if ((char_code == gwp_pkg::CH_PLUS) || (char_code == gwp_pkg::CH_MINUS)) begin
			if (word_q.started) begin
				fed.stopped = 1'b1;
			end else begin
				fed.started = 1'b1;
				fed.neg = char_code == gwp_pkg::CH_MINUS;
			end
		end else begin
			fed.stopped = 1'b1;
		end
	end

	// word splitting and result requests
	always_comb begin
		word_n = word_q;
		comment_n = comment_q;
		em_a_vld = 1'b0;
		em_b_vld = 1'b0;
		em_b_letter = gwp_pkg::NO_WORD;
		em_a.letter = word_q.letter;
		em_a.mag = word_q.mag;
		em_a.neg = word_q.neg;
		em_a.frac_cnt = word_q.frac_cnt;
		em_a.clamp = word_q.clamp;
		em_a.last = line_end;

		if (!comment_q) begin
			if ((char_code == gwp_pkg::CH_SEMI) || (char_code == gwp_pkg::CH_SPACE)) begin
				em_a_vld = word_q.letter != gwp_pkg::NO_WORD;
				word_n = gwp_pkg::WORD_CLEAR;
				if (char_code == gwp_pkg::CH_SEMI) begin
					comment_n = 1'b1;
				end
			end else if (is_letter) begin
				em_a_vld = word_q.letter != gwp_pkg::NO_WORD;
				em_a.last = line_end && (code == gwp_pkg::NO_WORD);
				word_n = gwp_pkg::WORD_CLEAR;
				word_n.letter = code;
			end else if ((word_q.letter != gwp_pkg::NO_WORD) && !word_q.stopped) begin
				word_n = fed;
			end
		end

		if (line_end) begin
			if (word_n.letter != gwp_pkg::NO_WORD) begin
				if (em_a_vld) begin
					em_b_vld = 1'b1;
					em_b_letter = word_n.letter;
				end else begin
					em_a_vld = 1'b1;
					em_a.letter = word_n.letter;
					em_a.mag = word_n.mag;
					em_a.neg = word_n.neg;
					em_a.frac_cnt = word_n.frac_cnt;
					em_a.clamp = word_n.clamp;
					em_a.last = 1'b1;
				end
			end
			word_n = gwp_pkg::WORD_CLEAR;
			comment_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= gwp_pkg::WORD_CLEAR;
			comment_q <= 1'b0;
			a_vld_s1 <= 1'b0;
			b_vld_s1 <= 1'b0;
		end else begin
			a_vld_s1 <= in_fire & em_a_vld;
			b_vld_s1 <= in_fire & em_b_vld;
			if (in_fire) begin
				word_q <= word_n;
				comment_q <= comment_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= em_a;
		b_letter_s1 <= em_b_letter;
	end

	gwp_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.a_vld_s1(a_vld_s1),
		.a_s1(a_s1),
		.b_vld_s1(b_vld_s1),
		.b_letter_s1(b_letter_s1),
		.push_a(push_a),
		.res_a(res_a),
		.push_b(push_b),
		.res_b(res_b)
	);

	// result queue, reserved at transfer so it never overflows
	assign n_new = in_fire ? (gwp_pkg::CNT_W'(em_a_vld) + gwp_pkg::CNT_W'(em_b_vld))
		: '0;
	assign n_push = gwp_pkg::CNT_W'(push_a) + gwp_pkg::CNT_W'(push_b);
	assign n_pop = gwp_pkg::CNT_W'(out_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
			res_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + gwp_pkg::PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + gwp_pkg::PTR_W'(n_pop);
			fill_q <= fill_q + n_push - n_pop;
			res_q <= res_q + n_new - n_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_ptr_q] <= res_a;
		end
		if (push_b) begin
			mem_q[wr_ptr_q + gwp_pkg::PTR_W'(1)] <= res_b;
		end
	end

	assign out_valid = fill_q != '0;
	assign word_letter = mem_q[rd_ptr_q].letter;
	assign word_value = mem_q[rd_ptr_q].value;
	assign value_saturated = mem_q[rd_ptr_q].sat;
	assign last_of_line = mem_q[rd_ptr_q].last;

`ifndef NO_ASSERTIONS
	a_fill_le_res: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= res_q)
		else $error("queue holds more than was reserved");
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= gwp_pkg::CNT_W'(gwp_pkg::FIFO_DEPTH))
		else $error("queue reservation beyond depth");
	a_b_needs_a: assert property (@(posedge clk) disable iff (!arst_n)
		b_vld_s1 |-> a_vld_s1)
		else $error("second result without a first");
	a_push_follows: assert property (@(posedge clk) disable iff (!arst_n)
		a_vld_s1 |=> push_a)
		else $error("result lost in scaling stage");
`endif

endmodule
`default_nettype wire

// ===== tb/gcode_word_parser_top_tb.sv =====
`timescale 1ns / 1ps
module gcode_word_parser_top_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam string KNOWN_LETTERS = "ABCXYZIJKFSPRTNMG";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = 8'd0;
	logic line_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] word_letter;
	logic signed [31:0] word_value;
	logic value_saturated;
	logic last_of_line;

	gcode_word_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.word_letter(word_letter),
		.word_value(word_value),
		.value_saturated(value_saturated),
		.last_of_line(last_of_line)
	);

	// tokenizer state of the predictor
	logic [4:0] tok_letter = gwp_pkg::NO_WORD;
	logic [31:0] tok_mag = 32'd0;
	logic tok_neg = 1'b0;
	logic tok_point = 1'b0;
	logic [2:0] tok_frac = 3'd0;
	logic tok_stopped = 1'b0;
	logic tok_clamp = 1'b0;
	logic tok_started = 1'b0;
	logic tok_comment = 1'b0;

	gwp_pkg::result_t pending_words[$];
	gwp_pkg::result_t want_word;
	logic [7:0] line_buf[$];

	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int stall_left = 0;
	int stall_pick;
	int errors = 0;
	int cycles = 0;
	int chars_sent = 0;
	int lines_sent = 0;
	int words_checked = 0;
	int sat_words = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task clear_word();
		tok_letter = gwp_pkg::NO_WORD;
		tok_mag = 32'd0;
		tok_neg = 1'b0;
		tok_point = 1'b0;
		tok_frac = 3'd0;
		tok_stopped = 1'b0;
		tok_clamp = 1'b0;
		tok_started = 1'b0;
	endtask

	task add_digit(input logic [3:0] d);
		logic [63:0] nxt;
		logic [63:0] lim;
		lim = tok_neg ? 64'd2147483648 : 64'd2147483647;
		nxt = 64'(tok_mag) * 64'd10 + 64'(d);
		if (nxt > lim) begin
			nxt = lim;
			tok_clamp = 1'b1;
		end
		tok_mag = nxt[31:0];
	endtask

	task push_word(input logic last);
		logic [63:0] v;
		logic [63:0] lim;
		logic sat;
		gwp_pkg::result_t w;
		v = 64'(tok_mag);
		for (int i = int'(tok_frac); i < gwp_pkg::FRAC_DIGITS; i++)
			v = v * 64'd10;
		lim = tok_neg ? 64'd2147483648 : 64'd2147483647;
		sat = tok_clamp;
		if (v > lim) begin
			v = lim;
			sat = 1'b1;
		end
		if (tok_neg)
			v = -v;
		w.letter = tok_letter;
		w.value = v[31:0];
		w.sat = sat;
		w.last = last;
		pending_words.push_back(w);
	endtask

	task parse_char(input logic [7:0] c, input logic e);
		logic [4:0] code;
		code = gwp_pkg::NO_WORD;
		if (!tok_comment) begin
			if (c == gwp_pkg::CH_SEMI || c == gwp_pkg::CH_SPACE) begin
				if (tok_letter != gwp_pkg::NO_WORD)
					push_word(e);
				clear_word();
				if (c == gwp_pkg::CH_SEMI)
					tok_comment = 1'b1;
			end else if (c >= gwp_pkg::CH_LETTER_LO && c <= gwp_pkg::CH_LETTER_HI) begin
				for (int k = 0; k < KNOWN_LETTERS.len(); k++)
					if (KNOWN_LETTERS[k] == c)
						code = 5'(k);
				if (tok_letter != gwp_pkg::NO_WORD)
					push_word(e && code == gwp_pkg::NO_WORD);
				clear_word();
				tok_letter = code;
			end else if (tok_letter != gwp_pkg::NO_WORD && !tok_stopped) begin
				if (c >= gwp_pkg::CH_ZERO && c <= gwp_pkg::CH_NINE) begin
					tok_started = 1'b1;
					if (!tok_point) begin
						add_digit(4'(c - gwp_pkg::CH_ZERO));
					end else if (tok_frac < gwp_pkg::FRAC_DIGITS) begin
						add_digit(4'(c - gwp_pkg::CH_ZERO));
						tok_frac = tok_frac + 3'd1;
					end
				end else if (c == gwp_pkg::CH_POINT) begin
					if (tok_point) begin
						tok_stopped = 1'b1;
					end else begin
						tok_point = 1'b1;
						tok_started = 1'b1;
					end
				end else if (c == gwp_pkg::CH_PLUS || c == gwp_pkg::CH_MINUS) begin
					if (tok_started) begin
						tok_stopped = 1'b1;
					end else begin
						tok_started = 1'b1;
						tok_neg = (c == gwp_pkg::CH_MINUS);
					end
				end else begin
					tok_stopped = 1'b1;
				end
			end
		end
		if (e) begin
			if (tok_letter != gwp_pkg::NO_WORD)
				push_word(1'b1);
			clear_word();
			tok_comment = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready)
			parse_char(char_code, line_end);
		if (out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: letter %0d value %0d", word_letter, word_value);
				errors++;
			end else begin
				want_word = pending_words.pop_front();
				if (word_letter !== want_word.letter) begin
					$error("word_letter: expected %0d, got %0d", want_word.letter, word_letter);
					errors++;
				end
				if (word_value !== want_word.value) begin
					$error("word_value: expected %0d, got %0d",
						$signed(want_word.value), word_value);
					errors++;
				end
				if (value_saturated !== want_word.sat) begin
					$error("value_saturated: expected %0b, got %0b",
						want_word.sat, value_saturated);
					errors++;
				end
				if (last_of_line !== want_word.last) begin
					$error("last_of_line: expected %0b, got %0b", want_word.last, last_of_line);
					errors++;
				end
				words_checked++;
				if (want_word.sat)
					sat_words++;
			end
		end
	end

	always @(negedge clk) begin
		if (!stalls_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = (stall_pick < 96) ? $urandom_range(0, 2) : $urandom_range(7, 39);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d words pending", cycles, pending_words.size());
			$display("[gcode_word_parser_top] ERROR");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_char(input logic [7:0] c, input logic e);
		int gap;
		int pick;
		gap = 0;
		if (gaps_on) begin
			pick = $urandom_range(0, 99);
			if (pick >= 92)
				gap = $urandom_range(6, 30);
			else if (pick >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		line_end <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit end_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], end_last && i == s.len() - 1);
	endtask

	task automatic build_line();
		string lim_text;
		int r;
		int n;
		line_buf.delete();
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 12))
				line_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 9) == 0)
			line_buf.push_back(8'($urandom_range(0, 255)));
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 99) < 85)
				line_buf.push_back(KNOWN_LETTERS[$urandom_range(0, 16)]);
			else
				line_buf.push_back(8'($urandom_range(gwp_pkg::CH_LETTER_LO,
					gwp_pkg::CH_LETTER_HI)));
			r = $urandom_range(0, 99);
			if (r < 5) begin
				case ($urandom_range(0, 4))
					0: lim_text = "214748.3647";
					1: lim_text = "214748.36479";
					2: lim_text = "214748.3648";
					3: lim_text = "-214748.3648";
					default: lim_text = "-214748.3649";
				endcase
				for (int i = 0; i < lim_text.len(); i++)
					line_buf.push_back(lim_text[i]);
			end else begin
				if (r < 25)
					line_buf.push_back(gwp_pkg::CH_MINUS);
				else if (r < 30)
					line_buf.push_back(gwp_pkg::CH_PLUS);
				r = $urandom_range(0, 99);
				n = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12);
				repeat (n)
					line_buf.push_back(gwp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 99) < 40) begin
					line_buf.push_back(gwp_pkg::CH_POINT);
					n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4) : $urandom_range(5, 7);
					repeat (n)
						line_buf.push_back(gwp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				end
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: line_buf.push_back(gwp_pkg::CH_POINT);
						1: line_buf.push_back(gwp_pkg::CH_PLUS);
						2: line_buf.push_back(gwp_pkg::CH_MINUS);
						default: line_buf.push_back(8'($urandom_range(0, 255)));
					endcase
					repeat ($urandom_range(0, 3))
						line_buf.push_back(gwp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				end
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				line_buf.push_back(gwp_pkg::CH_SPACE);
			end else if (r < 62) begin
				line_buf.push_back(gwp_pkg::CH_SPACE);
				line_buf.push_back(gwp_pkg::CH_SPACE);
			end else if (r < 70) begin
				line_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			line_buf.push_back(gwp_pkg::CH_SEMI);
			repeat ($urandom_range(0, 6))
				line_buf.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 99);
		if (r < 15)
			line_buf.push_back(KNOWN_LETTERS[$urandom_range(0, 16)]);
		else if (r < 22)
			line_buf.push_back(gwp_pkg::CH_SPACE);
	endtask

	// comment drops the rest of the line, line end with no open word
	task automatic test_comment_and_line_end();
		send_text("G1.5;Q", 1'b1);
		lines_sent++;
	endtask

	// sign after point, unknown letter, stray bytes, two words at one line end
	task automatic test_number_stop_and_word_pair();
		send_text("A-.5+3b", 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text("ZK", 1'b1);
		lines_sent++;
	endtask

	// clamp while accumulating, fraction digits beyond the kept ones
	task automatic test_clamp_and_fraction_drop();
		send_text("S999999.12345", 1'b1);
		lines_sent++;
	endtask

	task automatic test_random_lines(input int n_chars, input bit gaps, input bit stalls);
		int target;
		gaps_on = gaps;
		stalls_on = stalls;
		target = chars_sent + n_chars;
		while (chars_sent < target) begin
			build_line();
			for (int i = 0; i < line_buf.size(); i++)
				send_char(line_buf[i], i == line_buf.size() - 1);
			lines_sent++;
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_comment_and_line_end();
		test_number_stop_and_word_pair();
		test_clamp_and_fraction_drop();
		test_random_lines(250, 1'b0, 1'b0);
		test_random_lines(500, 1'b1, 1'b1);
		test_random_lines(250, 1'b0, 1'b1);
		test_random_lines(250, 1'b1, 1'b0);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d characters in %0d lines with random gaps and output stalls",
			chars_sent, lines_sent);
		$display("checked %0d words, %0d of them clamped", words_checked, sat_words);
		if (errors == 0)
			$display("[gcode_word_parser_top] OK");
		else
			$display("[gcode_word_parser_top] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/gwp_pkg.sv
hdl/gwp_scale.sv
hdl/gcode_word_parser_top.sv
tb/gcode_word_parser_top_tb.sv
